@@ rtl/dmrc_pkg.sv @@
// dmrc_pkg: shared constants and controller/datapath interface types
// for the direct-mapped read cache; no dependencies
package dmrc_pkg;

    // geometry
    localparam int LINE_BYTES = 16;
    localparam int NUM_LINES  = 8;
    localparam int MEM_BYTES  = 4096;

    localparam int WORD_W  = $clog2(LINE_BYTES);
    localparam int LINE_W  = $clog2(NUM_LINES);
    localparam int ADDR_W  = $clog2(MEM_BYTES);
    localparam int BLOCK_W = ADDR_W - WORD_W;
    localparam int TAG_W   = ADDR_W - WORD_W - LINE_W;
    localparam int CACHE_W = LINE_W + WORD_W;

    localparam int BYTE_W  = 8;
    localparam int MISS_W  = 16;
    localparam int TIME_W  = 32;

    localparam logic [MISS_W-1:0] MISS_MAX = '1;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    // opcodes
    localparam logic OP_PRELOAD = 1'b0;
    localparam logic OP_READ    = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_HIT_COST     = 1'b0;
    localparam logic REG_MISS_PENALTY = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic              latch;       // capture request fields
        logic              lookup;      // tag check, stats update, tag write on miss
        logic              mem_wr;      // preload write into backing memory
        logic              fill_rd;     // read one backing byte for refill
        logic [WORD_W-1:0] fill_idx;    // byte of the line being refilled
        logic              add_penalty; // add miss penalty to elapsed time
        logic              line_rd;     // read addressed byte from cache line
        logic              out_load;    // load response register
    } dmrc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_read;
        logic hit;
    } dmrc_status_t;

endpackage

@@ rtl/dmrc_datapath.sv @@
// dmrc_datapath: backing memory, cache line store, tags, statistics
// and response payload register; depends on dmrc_pkg
module dmrc_datapath
    import dmrc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                opcode,
    input  logic [ADDR_W-1:0]   address,
    input  logic [BYTE_W-1:0]   write_data,
    input  logic [BYTE_W-1:0]   hit_cost,
    input  logic [BYTE_W-1:0]   miss_penalty,
    input  dmrc_cmd_t           cmd,
    output dmrc_status_t        status,
    output logic [BYTE_W-1:0]   data_byte,
    output logic                was_miss,
    output logic [TAG_W-1:0]    tag,
    output logic [LINE_W-1:0]   line_index,
    output logic [WORD_W-1:0]   word_offset,
    output logic [BLOCK_W-1:0]  block_number,
    output logic [MISS_W-1:0]   miss_count,
    output logic [TIME_W-1:0]   elapsed_time
);

    // captured request
    logic                op_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [BYTE_W-1:0]   wdata_reg;
    logic                miss_reg;

    logic [WORD_W-1:0]   item_word;
    logic [LINE_W-1:0]   item_line;
    logic [TAG_W-1:0]    item_tag;
    logic [BLOCK_W-1:0]  item_block;

    // memories
    logic [BYTE_W-1:0]   back_mem [0:MEM_BYTES-1];
    logic [BYTE_W-1:0]   back_rdata_reg;
    logic [BYTE_W-1:0]   line_mem [0:NUM_LINES*LINE_BYTES-1];
    logic [BYTE_W-1:0]   line_rdata_reg;

    // refill write, in the cycle after the backing read
    logic                fill_wr_reg;
    logic [WORD_W-1:0]   fill_wr_idx_reg;

    // tags and valid bits
    logic [NUM_LINES-1:0] valid_reg;
    logic [TAG_W-1:0]     tag_reg [0:NUM_LINES-1];

    // statistics
    logic [MISS_W-1:0]   misses_reg;
    logic [TIME_W-1:0]   time_reg;
    logic [TIME_W:0]     time_sum;
    logic [BYTE_W-1:0]   time_addend;

    assign item_word  = addr_reg[WORD_W-1:0];
    assign item_line  = addr_reg[CACHE_W-1:WORD_W];
    assign item_tag   = addr_reg[ADDR_W-1:CACHE_W];
    assign item_block = addr_reg[ADDR_W-1:WORD_W];

    assign status.is_read = (op_reg == OP_READ);
    assign status.hit     = valid_reg[item_line] && (tag_reg[item_line] == item_tag);

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg    <= opcode;
            addr_reg  <= address;
            wdata_reg <= write_data;
        end
        if (cmd.lookup)
        begin
            miss_reg <= status.is_read && !status.hit;
        end
    end

    // backing memory: preload write, refill read
    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
        begin
            back_mem[addr_reg] <= wdata_reg;
        end
        if (cmd.fill_rd)
        begin
            back_rdata_reg <= back_mem[{item_block, cmd.fill_idx}];
        end
    end

    // refill write pipeline flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_wr_reg <= 1'b0;
        end
        else
        begin
            fill_wr_reg <= cmd.fill_rd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fill_rd)
        begin
            fill_wr_idx_reg <= cmd.fill_idx;
        end
    end

    // cache line store
    always_ff @(posedge clk)
    begin
        if (fill_wr_reg)
        begin
            line_mem[{item_line, fill_wr_idx_reg}] <= back_rdata_reg;
        end
        if (cmd.line_rd)
        begin
            line_rdata_reg <= line_mem[{item_line, item_word}];
        end
    end

    // tag store, written on a read miss
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.lookup && status.is_read && !status.hit)
        begin
            valid_reg[item_line] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LINES; i++)
            begin
                tag_reg[i] <= '0;
            end
        end
        else if (cmd.lookup && status.is_read && !status.hit)
        begin
            tag_reg[item_line] <= item_tag;
        end
    end

    // saturating elapsed time, hit cost at read lookup and penalty after refill
    assign time_addend = cmd.add_penalty ? miss_penalty : hit_cost;
    assign time_sum    = {1'b0, time_reg} + {{(TIME_W+1-BYTE_W){1'b0}}, time_addend};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg   <= '0;
            misses_reg <= '0;
        end
        else
        begin
            if ((cmd.lookup && status.is_read) || cmd.add_penalty)
            begin
                time_reg <= time_sum[TIME_W] ? TIME_MAX : time_sum[TIME_W-1:0];
            end
            if (cmd.lookup && status.is_read && !status.hit && (misses_reg != MISS_MAX))
            begin
                misses_reg <= misses_reg + MISS_W'(1);
            end
        end
    end

    // response payload register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            data_byte    <= status.is_read ? line_rdata_reg : '0;
            was_miss     <= status.is_read && miss_reg;
            tag          <= item_tag;
            line_index   <= item_line;
            word_offset  <= item_word;
            block_number <= item_block;
            miss_count   <= misses_reg;
            elapsed_time <= time_reg;
        end
    end

endmodule

@@ rtl/dmrc_ctrl.sv @@
// dmrc_ctrl: sequencing state machine for lookup, refill and response
// handshake; depends on dmrc_pkg
module dmrc_ctrl
    import dmrc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    input  dmrc_status_t  status,
    output dmrc_cmd_t     cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_FILL,
        ST_FILL_END,
        ST_LINE_RD,
        ST_RESULT
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [WORD_W-1:0]  fill_cnt_reg;
    logic [WORD_W-1:0]  fill_cnt_next;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    logic               req_accept;
    logic               out_free;

    assign req_stall  = (state_reg != ST_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign rsp_valid  = rsp_valid_reg;
    assign out_free   = !rsp_valid_reg || !rsp_stall;

    // next state and commands
    always_comb
    begin
        state_next      = state_reg;
        fill_cnt_next   = fill_cnt_reg;
        cmd             = '0;
        cmd.latch       = req_accept;
        cmd.fill_idx    = fill_cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                if (!status.is_read)
                begin
                    cmd.mem_wr = 1'b1;
                    state_next = ST_RESULT;
                end
                else if (status.hit)
                begin
                    cmd.line_rd = 1'b1;
                    state_next  = ST_RESULT;
                end
                else
                begin
                    fill_cnt_next = '0;
                    state_next    = ST_FILL;
                end
            end
            ST_FILL:
            begin
                cmd.fill_rd   = 1'b1;
                fill_cnt_next = fill_cnt_reg + WORD_W'(1);
                if (fill_cnt_reg == WORD_W'(LINE_BYTES - 1))
                begin
                    state_next = ST_FILL_END;
                end
            end
            ST_FILL_END:
            begin
                cmd.add_penalty = 1'b1;
                state_next      = ST_LINE_RD;
            end
            ST_LINE_RD:
            begin
                cmd.line_rd = 1'b1;
                state_next  = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // response valid: set on load, cleared when taken
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_cnt_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_cnt_reg  <= fill_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // an accepted request goes straight to the tag check
    assert property (@(posedge clk) disable iff (!rst_n)
        req_accept |=> state_reg == ST_LOOKUP)
        else $error("accepted request did not reach lookup");

    // a read miss installs the tag, so the request's tag check then reports a hit
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOKUP && status.is_read && !status.hit) |=> status.hit)
        else $error("tag not installed after miss");

    // response valid only rises out of the result state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_RESULT))
        else $error("response raised outside result state");

    // the fill counter starts each refill at the first byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOKUP) |=> fill_cnt_reg == '0)
        else $error("refill counter not cleared");

endmodule

@@ rtl/direct_mapped_read_cache.sv @@
// direct_mapped_read_cache: top level with configuration registers,
// controller and datapath; depends on dmrc_pkg, dmrc_ctrl, dmrc_datapath
//
//   channel   handshake               payload
//   request   req_valid / req_stall   opcode, address, write_data
//   response  rsp_valid / rsp_stall   data_byte .. elapsed_time
//   config    APB psel/penable/pready paddr, pwdata, prdata
//
// preload and read hit: lookup, then result;
// read miss adds a refill at one backing byte per cycle, then penalty and line read.
// one transaction is in flight; the next is taken once the response is registered,
// while that response may still wait under rsp_stall.
// reset clears valid bits, tags and counters and restores configuration defaults; no clearing pass.
module direct_mapped_read_cache
    import dmrc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // apb configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    // request
    input  logic                req_valid,
    output logic                req_stall,
    input  logic                opcode,
    input  logic [ADDR_W-1:0]   address,
    input  logic [BYTE_W-1:0]   write_data,
    // response
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output logic [BYTE_W-1:0]   data_byte,
    output logic                was_miss,
    output logic [TAG_W-1:0]    tag,
    output logic [LINE_W-1:0]   line_index,
    output logic [WORD_W-1:0]   word_offset,
    output logic [BLOCK_W-1:0]  block_number,
    output logic [MISS_W-1:0]   miss_count,
    output logic [TIME_W-1:0]   elapsed_time
);

    logic [BYTE_W-1:0]  hit_cost_reg;
    logic [BYTE_W-1:0]  miss_penalty_reg;
    logic               cfg_wr;
    logic               reg_sel;
    dmrc_cmd_t          cmd;
    dmrc_status_t       status;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_cost_reg     <= BYTE_W'(1);
            miss_penalty_reg <= BYTE_W'(10);
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                REG_HIT_COST:     hit_cost_reg     <= pwdata[BYTE_W-1:0];
                REG_MISS_PENALTY: miss_penalty_reg <= pwdata[BYTE_W-1:0];
                default:          hit_cost_reg     <= hit_cost_reg;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (reg_sel)
            REG_HIT_COST:     prdata = {{(32-BYTE_W){1'b0}}, hit_cost_reg};
            REG_MISS_PENALTY: prdata = {{(32-BYTE_W){1'b0}}, miss_penalty_reg};
            default:          prdata = '0;
        endcase
    end

    dmrc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .cmd       (cmd)
    );

    dmrc_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .opcode       (opcode),
        .address      (address),
        .write_data   (write_data),
        .hit_cost     (hit_cost_reg),
        .miss_penalty (miss_penalty_reg),
        .cmd          (cmd),
        .status       (status),
        .data_byte    (data_byte),
        .was_miss     (was_miss),
        .tag          (tag),
        .line_index   (line_index),
        .word_offset  (word_offset),
        .block_number (block_number),
        .miss_count   (miss_count),
        .elapsed_time (elapsed_time)
    );

endmodule

@@ tb/sv/direct_mapped_read_cache_test.sv @@
// direct_mapped_read_cache_test: self-checking testbench for the direct-mapped read cache
// holds its own cache/backing-memory predictor, a queued request driver and a response monitor
// depends on dmrc_pkg and direct_mapped_read_cache
module direct_mapped_read_cache_test;
    import dmrc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // one cache request and one cache reply
    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] wdata;
    } cache_req_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  data;
        logic               miss;
        logic [TAG_W-1:0]   tag;
        logic [LINE_W-1:0]  line;
        logic [WORD_W-1:0]  word;
        logic [BLOCK_W-1:0] block;
        logic [MISS_W-1:0]  misses;
        logic [TIME_W-1:0]  elapsed;
    } cache_reply_t;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;
    logic                req_valid;
    logic                req_stall;
    logic                opcode;
    logic [ADDR_W-1:0]   address;
    logic [BYTE_W-1:0]   write_data;
    logic                rsp_valid;
    logic                rsp_stall;
    logic [BYTE_W-1:0]   data_byte;
    logic                was_miss;
    logic [TAG_W-1:0]    tag;
    logic [LINE_W-1:0]   line_index;
    logic [WORD_W-1:0]   word_offset;
    logic [BLOCK_W-1:0]  block_number;
    logic [MISS_W-1:0]   miss_count;
    logic [TIME_W-1:0]   elapsed_time;

    // predictor state
    logic [BYTE_W-1:0]   mem_copy [MEM_BYTES];
    logic                line_ok [NUM_LINES];
    logic [TAG_W-1:0]    line_tag_copy [NUM_LINES];
    logic [BYTE_W-1:0]   line_data [NUM_LINES*LINE_BYTES];
    logic [MISS_W-1:0]   misses_copy;
    logic [TIME_W-1:0]   time_copy;
    logic [7:0]          hit_cost_copy;
    logic [7:0]          miss_penalty_copy;

    // stimulus bookkeeping
    bit                  byte_loaded [MEM_BYTES];
    cache_req_t          access_q[$];
    cache_reply_t        cache_reply_q[$];
    cache_req_t          held_req;
    cache_reply_t        reply_want;
    int                  sender_gap_pct;
    int                  receiver_hold_pct;
    int                  mismatch_cnt;

    direct_mapped_read_cache u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .opcode       (opcode),
        .address      (address),
        .write_data   (write_data),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .data_byte    (data_byte),
        .was_miss     (was_miss),
        .tag          (tag),
        .line_index   (line_index),
        .word_offset  (word_offset),
        .block_number (block_number),
        .miss_count   (miss_count),
        .elapsed_time (elapsed_time)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // saturating add for the elapsed time
    function automatic logic [TIME_W-1:0] time_add(logic [TIME_W-1:0] t, logic [7:0] inc);
        logic [TIME_W:0] s;
        s = {1'b0, t} + {{(TIME_W+1-8){1'b0}}, inc};
        return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
    endfunction

    // predict one accepted transaction and queue its reply
    function automatic void cache_access(cache_req_t rq);
        cache_reply_t       r;
        logic [BLOCK_W-1:0] blk;
        logic [LINE_W-1:0]  ln;
        logic [TAG_W-1:0]   tg;
        logic [WORD_W-1:0]  wd;
        blk = rq.addr[ADDR_W-1:WORD_W];
        ln  = blk[LINE_W-1:0];
        tg  = blk[BLOCK_W-1:LINE_W];
        wd  = rq.addr[WORD_W-1:0];
        r   = '0;
        if (rq.op == OP_PRELOAD)
        begin
            mem_copy[rq.addr] = rq.wdata;
        end
        else
        begin
            time_copy = time_add(time_copy, hit_cost_copy);
            if (!line_ok[ln] || line_tag_copy[ln] != tg)
            begin
                r.miss = 1'b1;
                if (misses_copy != MISS_MAX)
                    misses_copy++;
                for (int i = 0; i < LINE_BYTES; i++)
                    line_data[{ln, i[WORD_W-1:0]}] = mem_copy[{blk, i[WORD_W-1:0]}];
                line_ok[ln]       = 1'b1;
                line_tag_copy[ln] = tg;
                time_copy = time_add(time_copy, miss_penalty_copy);
            end
            r.data = line_data[{ln, wd}];
        end
        r.tag     = tg;
        r.line    = ln;
        r.word    = wd;
        r.block   = blk;
        r.misses  = misses_copy;
        r.elapsed = time_copy;
        cache_reply_q.push_back(r);
    endfunction

    // request driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                cache_access(held_req);
            if (!req_valid || !req_stall)
            begin
                if (access_q.size() > 0 && $urandom_range(0, 99) >= sender_gap_pct)
                begin
                    held_req = access_q.pop_front();
                    req_valid  <= 1'b1;
                    opcode     <= held_req.op;
                    address    <= held_req.addr;
                    write_data <= held_req.wdata;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, fname, want, got);
            mismatch_cnt++;
        end
    endtask

    // response monitor and receiver stalls
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            rsp_stall <= ($urandom_range(0, 99) < receiver_hold_pct);
            if (rsp_valid && !rsp_stall)
            begin
                if (cache_reply_q.size() == 0)
                begin
                    $display("%0t ns: reply with no transaction pending, expected none actual %0h",
                             $time, data_byte);
                    mismatch_cnt++;
                end
                else
                begin
                    reply_want = cache_reply_q.pop_front();
                    check_field("data_byte", 32'(reply_want.data), 32'(data_byte));
                    check_field("was_miss", 32'(reply_want.miss), 32'(was_miss));
                    check_field("tag", 32'(reply_want.tag), 32'(tag));
                    check_field("line_index", 32'(reply_want.line), 32'(line_index));
                    check_field("word_offset", 32'(reply_want.word), 32'(word_offset));
                    check_field("block_number", 32'(reply_want.block), 32'(block_number));
                    check_field("miss_count", 32'(reply_want.misses), 32'(miss_count));
                    check_field("elapsed_time", reply_want.elapsed, elapsed_time);
                end
            end
        end
    end

    // apb write: setup then access phase, register taken at the access edge
    task automatic write_reg(logic idx, logic [7:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'h0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_HIT_COST)
            hit_cost_copy = val;
        else
            miss_penalty_copy = val;
    endtask

    task automatic load_byte(logic [ADDR_W-1:0] a, logic [BYTE_W-1:0] d);
        access_q.push_back('{op: OP_PRELOAD, addr: a, wdata: d});
        byte_loaded[a] = 1'b1;
    endtask

    // a refill reads the whole block, so every byte of it gets preloaded first
    task automatic fill_block(logic [BLOCK_W-1:0] blk);
        logic [ADDR_W-1:0] a;
        for (int i = 0; i < LINE_BYTES; i++)
        begin
            a = {blk, i[WORD_W-1:0]};
            if (!byte_loaded[a])
                load_byte(a, BYTE_W'($urandom));
        end
    endtask

    task automatic read_byte(logic [ADDR_W-1:0] a);
        fill_block(a[ADDR_W-1:WORD_W]);
        access_q.push_back('{op: OP_READ, addr: a, wdata: BYTE_W'($urandom)});
    endtask

    // mixed traffic over a small set of conflicting blocks plus stray preloads
    task automatic random_traffic(int n_items, logic [TAG_W-1:0] tag_a, logic [TAG_W-1:0] tag_b);
        int                 goal;
        logic [LINE_W-1:0]  line_base;
        logic [LINE_W-1:0]  ln;
        logic [TAG_W-1:0]   tg;
        logic [ADDR_W-1:0]  a;
        goal      = access_q.size() + n_items;
        line_base = LINE_W'($urandom);
        while (access_q.size() < goal)
        begin
            ln = line_base + LINE_W'($urandom_range(0, 2));
            tg = $urandom_range(0, 1) ? tag_a : tag_b;
            a  = {tg, ln, WORD_W'($urandom)};
            if ($urandom_range(0, 99) < 25)
            begin
                if ($urandom_range(0, 1))
                    a = ADDR_W'($urandom);
                load_byte(a, BYTE_W'($urandom));
            end
            else
            begin
                read_byte(a);
            end
        end
    endtask

    // wait for the block to go idle
    task automatic wait_drain();
        do
            @(posedge clk);
        while (access_q.size() != 0 || req_valid || cache_reply_q.size() != 0);
        repeat (25) @(posedge clk);
    endtask

    // stimulus and phase sequencing
    initial
    begin
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        req_valid  = 1'b0;
        opcode     = OP_PRELOAD;
        address    = '0;
        write_data = '0;
        rsp_stall  = 1'b0;
        mismatch_cnt      = 0;
        sender_gap_pct    = 19;
        receiver_hold_pct = 73;
        held_req          = '0;
        for (int i = 0; i < MEM_BYTES; i++)
        begin
            mem_copy[i]    = '0;
            byte_loaded[i] = 1'b0;
        end
        for (int i = 0; i < NUM_LINES; i++)
        begin
            line_ok[i]       = 1'b0;
            line_tag_copy[i] = '0;
        end
        for (int i = 0; i < NUM_LINES*LINE_BYTES; i++)
            line_data[i] = 8'h23;
        misses_copy       = '0;
        time_copy         = '0;
        hit_cost_copy     = 8'd1;
        miss_penalty_copy = 8'd10;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset configuration, extremes and conflicts on line 0
        load_byte(12'hFFF, 8'hFF);
        load_byte(12'h000, 8'h00);
        load_byte(12'h00F, 8'hFF);
        read_byte(12'h000);           // invalid line whose reset tag matches: miss
        read_byte(12'h00F);           // hit
        read_byte(12'hF80);           // top tag on the same line: conflict miss
        read_byte(12'hF8F);           // hit
        read_byte(12'h000);           // evicted block comes back: miss
        load_byte(12'h005, 8'hA5);    // preload under a cached line
        read_byte(12'h005);           // hit returns the stale cached byte
        wait_drain();

        // random phases, each under its own configuration and idle mix
        write_reg(REG_HIT_COST, 8'hFF);
        write_reg(REG_MISS_PENALTY, 8'hFF);
        random_traffic(200, '0, '1);
        wait_drain();

        sender_gap_pct    = 73;
        receiver_hold_pct = 19;
        write_reg(REG_HIT_COST, 8'h00);
        write_reg(REG_MISS_PENALTY, 8'h00);
        random_traffic(200, TAG_W'($urandom), TAG_W'($urandom));
        wait_drain();

        sender_gap_pct    = 0;
        receiver_hold_pct = 0;
        write_reg(REG_HIT_COST, 8'($urandom));
        write_reg(REG_MISS_PENALTY, 8'($urandom));
        random_traffic(200, TAG_W'($urandom), TAG_W'($urandom));
        wait_drain();

        if (mismatch_cnt == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // hang guard
    initial
    begin
        #5000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
